>>> src/tcdt_pkg.sv
// ----------------------------------------------------------------------------
// tcdt_pkg
// Shared types and constants of the touch contact debounce tracker.
// ----------------------------------------------------------------------------
package tcdt_pkg;

    localparam int HOLD_W     = 8;
    localparam int POS_W      = 16;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = HOLD_W;

    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_HOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_HOLD   = 1'd1;

    localparam logic [HOLD_W-1:0]        RELEASE_HOLD_RST = 8'd10;
    localparam logic [HOLD_W-1:0]        PRESS_HOLD_RST   = 8'd2;
    localparam logic signed [POS_W-1:0]  POS_RST          = -16'sd1;
    localparam logic [TIME_W-1:0]        TIME_RST         = '0;

    typedef struct packed {
        logic                    contact_present;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [TIME_W-1:0]       sample_time;
    } t_sample;

    typedef struct packed {
        logic                    began;
        logic                    moved;
        logic                    ended;
        logic signed [POS_W-1:0] start_x;
        logic signed [POS_W-1:0] start_y;
        logic [TIME_W-1:0]       start_time;
        logic signed [POS_W-1:0] latest_x;
        logic signed [POS_W-1:0] latest_y;
        logic [TIME_W-1:0]       latest_time;
    } t_result;

    typedef struct packed {
        logic [HOLD_W-1:0] release_hold;
        logic [HOLD_W-1:0] press_hold;
    } t_limits;

endpackage

>>> src/tcdt_if.sv
// ----------------------------------------------------------------------------
// tcdt_if
// Valid/ready channels for sample items and result items.
// ----------------------------------------------------------------------------
interface tcdt_in_if import tcdt_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tcdt_out_if import tcdt_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/tcdt_core.sv
// ----------------------------------------------------------------------------
// tcdt_core
// Hysteresis debounce counter and contact capture registers.
// ----------------------------------------------------------------------------
module tcdt_core import tcdt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_sample i_sample,
    input  t_limits i_limits,
    output t_result o_result
);

    logic                    r_touching, n_touching;
    logic [HOLD_W-1:0]       r_count, n_count;
    logic signed [POS_W-1:0] r_first_x, r_first_y, r_last_x, r_last_y;
    logic [TIME_W-1:0]       r_first_time, r_last_time;

    logic [HOLD_W-1:0] cur_lim, new_lim;
    logic [HOLD_W:0]   up;
    logic              capture, first;

    always_comb begin
        cur_lim = r_touching ? i_limits.press_hold : i_limits.release_hold;
        new_lim = i_sample.contact_present ? i_limits.press_hold : i_limits.release_hold;
        up      = {1'b0, r_count} + {{HOLD_W{1'b0}}, 1'b1};
        n_touching = r_touching;
        n_count    = r_count;
        if (i_sample.contact_present == r_touching) begin
            n_count = (up < {1'b0, cur_lim}) ? up[HOLD_W-1:0] : cur_lim;
        end else if (r_count <= {{(HOLD_W-1){1'b0}}, 1'b1}) begin
            n_touching = i_sample.contact_present;
            n_count    = new_lim;
        end else begin
            n_count = r_count - {{(HOLD_W-1){1'b0}}, 1'b1};
        end
        capture = i_sample.contact_present && n_touching;
        first   = capture && !r_touching;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touching   <= 1'b0;
            r_count      <= RELEASE_HOLD_RST;
            r_first_x    <= POS_RST;
            r_first_y    <= POS_RST;
            r_first_time <= TIME_RST;
            r_last_x     <= POS_RST;
            r_last_y     <= POS_RST;
            r_last_time  <= TIME_RST;
        end else if (i_en) begin
            r_touching <= n_touching;
            r_count    <= n_count;
            if (capture) begin
                r_last_x    <= i_sample.pos_x;
                r_last_y    <= i_sample.pos_y;
                r_last_time <= i_sample.sample_time;
            end
            if (first) begin
                r_first_x    <= i_sample.pos_x;
                r_first_y    <= i_sample.pos_y;
                r_first_time <= i_sample.sample_time;
            end
        end
    end

    always_comb begin
        o_result.began       = first;
        o_result.moved       = capture;
        o_result.ended       = r_touching && !n_touching;
        o_result.start_x     = first ? i_sample.pos_x : r_first_x;
        o_result.start_y     = first ? i_sample.pos_y : r_first_y;
        o_result.start_time  = first ? i_sample.sample_time : r_first_time;
        o_result.latest_x    = capture ? i_sample.pos_x : r_last_x;
        o_result.latest_y    = capture ? i_sample.pos_y : r_last_y;
        o_result.latest_time = capture ? i_sample.sample_time : r_last_time;
    end

endmodule

>>> src/touch_contact_debounce_tracker_top.sv
// ----------------------------------------------------------------------------
// touch_contact_debounce_tracker_top
// Debounces touch samples and reports contact start, move and end events.
// The result is registered: it becomes valid in the cycle after the sample is accepted.
// Throughput: one item per cycle while the receiver takes results; the result register frees as it is taken.
// Reset: synchronous, active low; limits return to 10 and 2, state released.
// ----------------------------------------------------------------------------
module touch_contact_debounce_tracker_top import tcdt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tcdt_in_if.sink               i_in,
    tcdt_out_if.source            o_out
);

    t_limits r_limits;
    t_result core_result;
    t_result r_result;
    logic    r_valid;
    logic    accept;

    assign i_in.ready = !r_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.release_hold <= RELEASE_HOLD_RST;
            r_limits.press_hold   <= PRESS_HOLD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RELEASE_HOLD: r_limits.release_hold <= i_cfg_data;
                CFG_PRESS_HOLD:   r_limits.press_hold   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tcdt_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (accept),
        .i_sample (i_in.data),
        .i_limits (r_limits),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= core_result;
        end
    end

    assign o_out.valid = r_valid;
    assign o_out.data  = r_result;

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the touch contact debounce tracker against an in-bench tracker model.
// Sample items go in over a bursty valid/ready channel and result items are
// taken by a receiver that stalls on a changing pattern. Every result is
// compared field by field with the tracker model's prediction. The run covers
// reset limits, zero limits, limits lowered below the live count, a range of
// random limit settings and the largest limits.
// ----------------------------------------------------------------------------
module testbench;
    import tcdt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {RX_STREAM, RX_RANDOM, RX_PERIODIC, RX_STARVED} t_rx_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    tcdt_in_if  samples ();
    tcdt_out_if results ();

    touch_contact_debounce_tracker_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (samples),
        .o_out      (results)
    );

    // Tracker model state
    t_limits                 trk_limits;
    logic                    trk_touching;
    logic [HOLD_W-1:0]       trk_count;
    logic signed [POS_W-1:0] trk_first_x, trk_first_y, trk_last_x, trk_last_y;
    logic [TIME_W-1:0]       trk_first_time, trk_last_time;

    t_result     pending_results [$];
    int          mismatches;
    int          samples_taken;
    int          results_checked;
    int          contacts_began;
    int          contacts_ended;
    int          limit_settings;
    int          burst_left;
    logic [31:0] sample_clock;
    t_rx_mode    rx_mode;
    int          rx_left;
    int          rx_tick;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic t_result track_sample(t_sample s);
        t_result           r;
        logic              was;
        logic [HOLD_W-1:0] lim;
        was = trk_touching;
        lim = trk_touching ? trk_limits.press_hold : trk_limits.release_hold;
        if (s.contact_present == trk_touching) begin
            if (int'(trk_count) + 1 < int'(lim))
                trk_count = trk_count + 1'b1;
            else
                trk_count = lim;
        end else if (trk_count <= 1) begin
            trk_touching = s.contact_present;
            trk_count = s.contact_present ? trk_limits.press_hold : trk_limits.release_hold;
        end else begin
            trk_count = trk_count - 1'b1;
        end
        r = '0;
        r.ended = was && !trk_touching;
        if (s.contact_present && trk_touching) begin
            trk_last_x = s.pos_x;
            trk_last_y = s.pos_y;
            trk_last_time = s.sample_time;
            r.moved = 1'b1;
            if (!was) begin
                trk_first_x = s.pos_x;
                trk_first_y = s.pos_y;
                trk_first_time = s.sample_time;
                r.began = 1'b1;
            end
        end
        r.start_x = trk_first_x;
        r.start_y = trk_first_y;
        r.start_time = trk_first_time;
        r.latest_x = trk_last_x;
        r.latest_y = trk_last_y;
        r.latest_time = trk_last_time;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            trk_limits.release_hold = RELEASE_HOLD_RST;
            trk_limits.press_hold = PRESS_HOLD_RST;
            trk_touching = 1'b0;
            trk_count = RELEASE_HOLD_RST;
            trk_first_x = POS_RST;
            trk_first_y = POS_RST;
            trk_last_x = POS_RST;
            trk_last_y = POS_RST;
            trk_first_time = TIME_RST;
            trk_last_time = TIME_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RELEASE_HOLD: trk_limits.release_hold = i_cfg_data;
                    CFG_PRESS_HOLD:   trk_limits.press_hold = i_cfg_data;
                    default: ;
                endcase
            end
            if (samples.valid && samples.ready) begin
                pending_results.push_back(track_sample(samples.data));
                samples_taken++;
            end
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && results.valid && results.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result item, expected none, actual %h",
                         $time, results.data);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (want.began) contacts_began++;
                if (want.ended) contacts_ended++;
                check_field("began", want.began, results.data.began);
                check_field("moved", want.moved, results.data.moved);
                check_field("ended", want.ended, results.data.ended);
                check_field("start_x", want.start_x, results.data.start_x);
                check_field("start_y", want.start_y, results.data.start_y);
                check_field("start_time", want.start_time, results.data.start_time);
                check_field("latest_x", want.latest_x, results.data.latest_x);
                check_field("latest_y", want.latest_y, results.data.latest_y);
                check_field("latest_time", want.latest_time, results.data.latest_time);
            end
        end
    end

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(8, 60);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_STREAM:   results.ready <= 1'b1;
            RX_RANDOM:   results.ready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: results.ready <= (rx_tick % 4 == 0);
            RX_STARVED:  results.ready <= ($urandom_range(0, 7) == 0);
            default:     results.ready <= 1'b1;
        endcase
    end

    function automatic logic signed [POS_W-1:0] rand_pos();
        return POS_W'($urandom);
    endfunction

    function automatic logic [TIME_W-1:0] next_time();
        if ($urandom_range(0, 49) == 0)
            sample_clock = $urandom;
        else
            sample_clock = sample_clock + $urandom_range(1, 5000);
        return sample_clock;
    endfunction

    task automatic send_sample(logic present, logic signed [POS_W-1:0] x,
                               logic signed [POS_W-1:0] y, logic [TIME_W-1:0] t);
        t_sample s;
        int      gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                samples.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s.contact_present = present;
        s.pos_x = x;
        s.pos_y = y;
        s.sample_time = t;
        samples.valid <= 1'b1;
        samples.data <= s;
        do @(posedge i_clk); while (!samples.ready);
    endtask

    task automatic wait_drained();
        samples.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_limits(logic [HOLD_W-1:0] release_lim, logic [HOLD_W-1:0] press_lim);
        write_limit(CFG_RELEASE_HOLD, release_lim);
        write_limit(CFG_PRESS_HOLD, press_lim);
        limit_settings++;
    endtask

    task automatic test_default_limits();
        logic signed [POS_W-1:0] corner [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
        logic [TIME_W-1:0]       stamp [3] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000};
        send_sample(1'b0, corner[0], corner[1], stamp[1]);
        for (int i = 0; i < 11; i++)
            send_sample(1'b1, corner[i % 4], corner[(i + 1) % 4], stamp[i % 3]);
        send_sample(1'b0, corner[2], corner[3], stamp[0]);
        send_sample(1'b0, corner[1], corner[0], stamp[2]);
        send_sample(1'b1, corner[3], corner[2], stamp[1]);
        send_sample(1'b0, corner[0], corner[0], stamp[0]);
    endtask

    task automatic test_zero_limits();
        set_limits(8'd0, 8'd0);
        repeat (3) send_sample(1'b1, rand_pos(), rand_pos(), next_time());
        repeat (3) send_sample(1'b0, rand_pos(), rand_pos(), next_time());
        for (int i = 0; i < 6; i++)
            send_sample(1'(i % 2), rand_pos(), rand_pos(), next_time());
    endtask

    task automatic test_lowered_limit();
        set_limits(8'd12, 8'd12);
        repeat (30) send_sample(1'b1, rand_pos(), rand_pos(), next_time());
        write_limit(CFG_PRESS_HOLD, 8'd3);
        send_sample(1'b1, rand_pos(), rand_pos(), next_time());
        write_limit(CFG_PRESS_HOLD, 8'd12);
        repeat (12) send_sample(1'b1, rand_pos(), rand_pos(), next_time());
        write_limit(CFG_PRESS_HOLD, 8'd3);
        repeat (14) send_sample(1'b0, rand_pos(), rand_pos(), next_time());
    endtask

    task automatic run_random_phase(logic [HOLD_W-1:0] release_lim, logic [HOLD_W-1:0] press_lim,
                                    int n_items, int min_run, int max_run);
        int   sent;
        int   run;
        logic level;
        set_limits(release_lim, press_lim);
        level = 1'($urandom_range(0, 1));
        sent = 0;
        while (sent < n_items) begin
            run = ($urandom_range(0, 4) == 0) ? $urandom_range(1, min_run)
                                              : $urandom_range(min_run, max_run);
            for (int k = 0; k < run && sent < n_items; k++) begin
                send_sample(($urandom_range(0, 15) == 0) ? !level : level,
                            rand_pos(), rand_pos(), next_time());
                sent++;
                if (sent == n_items / 2)
                    wait_drained();
            end
            level = !level;
        end
    endtask

    task automatic test_random_tracking();
        int rel;
        int prs;
        int top;
        run_random_phase(8'd1, 8'd1, 120, 2, 6);
        run_random_phase(8'd2, 8'd3, 120, 4, 9);
        run_random_phase(8'd6, 8'd1, 120, 7, 15);
        repeat (2) begin
            rel = $urandom_range(1, 16);
            prs = $urandom_range(1, 16);
            top = (rel > prs) ? rel : prs;
            run_random_phase(HOLD_W'(rel), HOLD_W'(prs), 110, top + 1, 2 * top + 3);
        end
    endtask

    task automatic test_max_limits();
        run_random_phase(8'd255, 8'd255, 560, 256, 300);
    endtask

    initial begin
        mismatches = 0;
        samples_taken = 0;
        results_checked = 0;
        contacts_began = 0;
        contacts_ended = 0;
        limit_settings = 0;
        burst_left = 0;
        rx_left = 0;
        rx_tick = 0;
        sample_clock = $urandom;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_RELEASE_HOLD;
        i_cfg_data <= '0;
        samples.valid <= 1'b0;
        samples.data <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_limits();
        test_zero_limits();
        test_lowered_limit();
        test_random_tracking();
        test_max_limits();

        wait_drained();
        repeat (4) @(posedge i_clk);
        $display("Ran %0d samples under %0d limit settings plus reset limits;",
                 samples_taken, limit_settings);
        $display("checked %0d results, %0d contacts began and %0d ended.",
                 results_checked, contacts_began, contacts_ended);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> filelist.f
src/tcdt_pkg.sv
src/tcdt_if.sv
src/tcdt_core.sv
src/touch_contact_debounce_tracker_top.sv
tb/testbench.sv
